/* src/assert_macros.svh */
// Assertion macros used by the top level RTL file of the scheduler.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* src/prq_pkg.sv */
// Package of the priority ready queue scheduler: codes, widths, state type.
// Used by prq_queue and the top level; depends on nothing.
`default_nettype none
package prq_pkg;
	localparam int MAX_THREADS  = 16;
	localparam int MAX_PRIORITY = 63;
	localparam int TICK_BITS    = 32;
	localparam int ID_W         = 4;
	localparam int PRIO_W       = 6;
	localparam int SLICE_W      = 8;

	localparam logic [2:0] REQ_CREATE = 3'd0;
	localparam logic [2:0] REQ_YIELD  = 3'd1;
	localparam logic [2:0] REQ_BLOCK  = 3'd2;
	localparam logic [2:0] REQ_SLEEP  = 3'd3;
	localparam logic [2:0] REQ_TICK   = 3'd4;
	localparam logic [2:0] REQ_SETPRI = 3'd5;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_IDLE_ERR = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXEC, ST_RSCAN, ST_CCHK, ST_YIELD,
		ST_SSCAN, ST_WAKE, ST_TPOST, ST_DONE
	} state_t;

	typedef struct packed {
		logic scan_clr;
		logic scan_adv;
		logic insert;
		logic pop;
	} qcmd_t;

	typedef struct packed {
		logic scan_more;
		logic empty;
		logic full;
	} qstat_t;
endpackage
`default_nettype wire

/* src/prq_queue.sv */
// Sorted queue of register cells with one shared key comparator. Uses prq_pkg.
// A scan walks one position a cycle; insert shifts cells above it, pop shifts all.
`default_nettype none
module prq_queue #(
	parameter int DEPTH  = prq_pkg::MAX_THREADS,
	parameter int KEY_W  = prq_pkg::TICK_BITS,
	parameter int DATA_W = prq_pkg::ID_W
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire prq_pkg::qcmd_t        cmd,
	input  wire [KEY_W-1:0]            key_in,
	input  wire [DATA_W-1:0]           data_in,
	output prq_pkg::qstat_t            stat,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic [KEY_W-1:0]           front_key,
	output logic [DATA_W-1:0]          front_data
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [KEY_W-1:0]  keys_q [DEPTH];
	logic [DATA_W-1:0] data_q [DEPTH];
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     pos_q;
	logic [KEY_W-1:0]  pos_key;

	assign pos_key        = keys_q[pos_q[IW-1:0]];
	// keep walking past entries whose key does not exceed the new key
	assign stat.scan_more = (pos_q < count_q) && (pos_key <= key_in);
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CW'(DEPTH));
	assign count          = count_q;
	assign front_key      = keys_q[0];
	assign front_data     = data_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.scan_clr)
				pos_q <= '0;
			else if (cmd.scan_adv)
				pos_q <= pos_q + CW'(1);
			if (cmd.insert && !cmd.pop)
				count_q <= count_q + CW'(1);
			else if (cmd.pop && !cmd.insert)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.insert) begin
				if (CW'(i) > pos_q && i > 0) begin
					keys_q[i] <= keys_q[(i > 0) ? i - 1 : 0];
					data_q[i] <= data_q[(i > 0) ? i - 1 : 0];
				end else if (CW'(i) == pos_q) begin
					keys_q[i] <= key_in;
					data_q[i] <= data_in;
				end
			end else if (cmd.pop && i < DEPTH - 1) begin
				keys_q[i] <= keys_q[(i < DEPTH - 1) ? i + 1 : i];
				data_q[i] <= data_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end
endmodule
`default_nettype wire

/* src/priority_ready_queue_with_sleep_timer.sv */
// Fixed-priority preemptive scheduler with sleep timer; one request per start.
// Block and non-preempting set priority: EXEC, DONE; yield with nothing better: EXEC, YIELD, DONE;
// an insert scans the queue one entry a cycle; a tick inserts each woken sleeper that way.
// busy stays high until done; the next start is taken the cycle after done.
// Reset (arst_n low, asynchronous): idle, queues empty, slice limit 4. Results cannot stall.
`default_nettype none
`include "assert_macros.svh"
module priority_ready_queue_with_sleep_timer #(
	parameter int MAX_THREADS = prq_pkg::MAX_THREADS
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          slice_limit_we,
	input  wire [prq_pkg::SLICE_W-1:0]   slice_limit,
	input  wire                          start,
	output logic                         busy,
	input  wire [2:0]                    req_type,
	input  wire [prq_pkg::ID_W-1:0]      thread_id,
	input  wire [prq_pkg::PRIO_W-1:0]    priority_req,
	input  wire [31:0]                   tick_value,
	output logic                         done,
	output logic [prq_pkg::ID_W-1:0]     running_id,
	output logic                         running_idle,
	output logic                         switched,
	output logic [1:0]                   status
);
	localparam int CW = $clog2(MAX_THREADS + 1);
	localparam int TW = prq_pkg::TICK_BITS;
	localparam int PW = prq_pkg::PRIO_W;
	localparam int IDW = prq_pkg::ID_W;
	localparam int SW = prq_pkg::SLICE_W;

	prq_pkg::state_t  state_q, state_d, cont_q, cont_d;
	prq_pkg::status_t status_q, status_d;
	logic [2:0]       req_q, req_d;
	logic [IDW-1:0]   id_q, id_d, ins_id_q, ins_id_d, cur_id_q, cur_id_d;
	logic [PW-1:0]    prio_q, prio_d, ins_prio_q, ins_prio_d, cur_prio_q, cur_prio_d;
	logic [TW-1:0]    tick_q, tick_d, early_q, early_d;
	logic             idle_q, idle_d, sw_q, sw_d;
	logic [SW-1:0]    slice_q, slice_d, slice_inc, ts_q;

	prq_pkg::qcmd_t  rcmd, scmd;
	prq_pkg::qstat_t rstat, sstat;
	logic [CW-1:0]   rcount, scount;
	logic [PW-1:0]   rfront_key, rfront_prio;
	logic [IDW-1:0]  rfront_id;
	logic [TW-1:0]   sfront_tick;
	logic [PW+IDW-1:0] sfront_data;

	prq_queue #(.DEPTH(MAX_THREADS), .KEY_W(PW), .DATA_W(IDW)) u_ready (
		.clk(clk), .arst_n(arst_n), .cmd(rcmd), .key_in(~ins_prio_q),
		.data_in(ins_id_q), .stat(rstat), .count(rcount),
		.front_key(rfront_key), .front_data(rfront_id)
	);

	prq_queue #(.DEPTH(MAX_THREADS), .KEY_W(TW), .DATA_W(PW + IDW)) u_sleep (
		.clk(clk), .arst_n(arst_n), .cmd(scmd), .key_in(tick_q),
		.data_in({cur_prio_q, cur_id_q}), .stat(sstat), .count(scount),
		.front_key(sfront_tick), .front_data(sfront_data)
	);

	// ready keys are stored inverted so both queues sort ascending
	assign rfront_prio = ~rfront_key;
	assign slice_inc   = (slice_q == '1) ? slice_q : slice_q + SW'(1);

	assign busy         = (state_q != prq_pkg::ST_IDLE);
	assign done         = (state_q == prq_pkg::ST_DONE);
	assign running_id   = idle_q ? '0 : cur_id_q;
	assign running_idle = idle_q;
	assign switched     = sw_q;
	assign status       = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= prq_pkg::ST_IDLE;
			cont_q     <= prq_pkg::ST_DONE;
			status_q   <= prq_pkg::STAT_OK;
			cur_id_q   <= '0;
			cur_prio_q <= '0;
			idle_q     <= 1'b1;
			slice_q    <= '0;
			early_q    <= '1;
			sw_q       <= 1'b0;
			ts_q       <= SW'(4);
		end else begin
			state_q    <= state_d;
			cont_q     <= cont_d;
			status_q   <= status_d;
			cur_id_q   <= cur_id_d;
			cur_prio_q <= cur_prio_d;
			idle_q     <= idle_d;
			slice_q    <= slice_d;
			early_q    <= early_d;
			sw_q       <= sw_d;
			if (slice_limit_we)
				ts_q <= slice_limit;
		end
	end

	always_ff @(posedge clk) begin
		req_q      <= req_d;
		id_q       <= id_d;
		prio_q     <= prio_d;
		tick_q     <= tick_d;
		ins_id_q   <= ins_id_d;
		ins_prio_q <= ins_prio_d;
	end

	always_comb begin
		state_d    = state_q;
		cont_d     = cont_q;
		status_d   = status_q;
		req_d      = req_q;
		id_d       = id_q;
		prio_d     = prio_q;
		tick_d     = tick_q;
		ins_id_d   = ins_id_q;
		ins_prio_d = ins_prio_q;
		cur_id_d   = cur_id_q;
		cur_prio_d = cur_prio_q;
		idle_d     = idle_q;
		slice_d    = slice_q;
		early_d    = early_q;
		sw_d       = sw_q;
		rcmd       = '0;
		scmd       = '0;
		case (state_q)
			prq_pkg::ST_IDLE: begin
				if (start) begin
					req_d    = req_type;
					id_d     = thread_id;
					prio_d   = (int'(priority_req) > prq_pkg::MAX_PRIORITY) ?
					           PW'(prq_pkg::MAX_PRIORITY) : priority_req;
					tick_d   = tick_value[TW-1:0];
					sw_d     = 1'b0;
					status_d = prq_pkg::STAT_OK;
					state_d  = prq_pkg::ST_EXEC;
				end
			end
			prq_pkg::ST_EXEC: begin
				state_d = prq_pkg::ST_DONE;
				case (req_q)
					prq_pkg::REQ_CREATE: begin
						if (rstat.full) begin
							status_d = prq_pkg::STAT_FULL;
						end else begin
							ins_id_d      = id_q;
							ins_prio_d    = prio_q;
							rcmd.scan_clr = 1'b1;
							cont_d        = prq_pkg::ST_CCHK;
							state_d       = prq_pkg::ST_RSCAN;
						end
					end
					prq_pkg::REQ_YIELD: state_d = prq_pkg::ST_YIELD;
					prq_pkg::REQ_BLOCK: begin
						if (idle_q) begin
							status_d = prq_pkg::STAT_IDLE_ERR;
						end else begin
							if (rstat.empty) begin
								idle_d = 1'b1; cur_id_d = '0; cur_prio_d = '0;
							end else begin
								idle_d = 1'b0; cur_id_d = rfront_id;
								cur_prio_d = rfront_prio; rcmd.pop = 1'b1;
							end
							slice_d = '0;
							sw_d    = 1'b1;
						end
					end
					prq_pkg::REQ_SLEEP: begin
						if (idle_q) begin
							status_d = prq_pkg::STAT_IDLE_ERR;
						end else if (sstat.full) begin
							status_d = prq_pkg::STAT_FULL;
						end else begin
							scmd.scan_clr = 1'b1;
							state_d       = prq_pkg::ST_SSCAN;
						end
					end
					prq_pkg::REQ_TICK: begin
						state_d = (tick_q < early_q) ? prq_pkg::ST_TPOST : prq_pkg::ST_WAKE;
					end
					prq_pkg::REQ_SETPRI: begin
						if (!idle_q) begin
							cur_prio_d = prio_q;
							if (!rstat.empty && prio_q < rfront_prio)
								state_d = prq_pkg::ST_YIELD;
						end
					end
					default: state_d = prq_pkg::ST_DONE;
				endcase
			end
			prq_pkg::ST_RSCAN: begin
				if (rstat.scan_more) begin
					rcmd.scan_adv = 1'b1;
				end else begin
					rcmd.insert = 1'b1;
					state_d     = cont_q;
				end
			end
			prq_pkg::ST_CCHK: begin
				state_d = (idle_q || cur_prio_q < rfront_prio) ?
				          prq_pkg::ST_YIELD : prq_pkg::ST_DONE;
			end
			prq_pkg::ST_YIELD: begin
				state_d = prq_pkg::ST_DONE;
				slice_d = '0;
				if (idle_q) begin
					if (!rstat.empty) begin
						idle_d = 1'b0; cur_id_d = rfront_id;
						cur_prio_d = rfront_prio; rcmd.pop = 1'b1;
						sw_d = 1'b1;
					end
				end else if (!rstat.empty && rfront_prio >= cur_prio_q) begin
					// requeue the old thread behind its equals
					ins_id_d      = cur_id_q;
					ins_prio_d    = cur_prio_q;
					cur_id_d      = rfront_id;
					cur_prio_d    = rfront_prio;
					rcmd.pop      = 1'b1;
					rcmd.scan_clr = 1'b1;
					sw_d          = 1'b1;
					cont_d        = prq_pkg::ST_DONE;
					state_d       = prq_pkg::ST_RSCAN;
				end
			end
			prq_pkg::ST_SSCAN: begin
				if (sstat.scan_more) begin
					scmd.scan_adv = 1'b1;
				end else begin
					scmd.insert = 1'b1;
					if (tick_q < early_q)
						early_d = tick_q;
					if (rstat.empty) begin
						idle_d = 1'b1; cur_id_d = '0; cur_prio_d = '0;
					end else begin
						idle_d = 1'b0; cur_id_d = rfront_id;
						cur_prio_d = rfront_prio; rcmd.pop = 1'b1;
					end
					slice_d = '0;
					sw_d    = 1'b1;
					state_d = prq_pkg::ST_DONE;
				end
			end
			prq_pkg::ST_WAKE: begin
				if (!sstat.empty && sfront_tick <= tick_q) begin
					if (rstat.full) begin
						status_d = prq_pkg::STAT_FULL;
						early_d  = sfront_tick;
						state_d  = prq_pkg::ST_TPOST;
					end else begin
						ins_id_d      = sfront_data[IDW-1:0];
						ins_prio_d    = sfront_data[PW+IDW-1:IDW];
						scmd.pop      = 1'b1;
						rcmd.scan_clr = 1'b1;
						cont_d        = prq_pkg::ST_WAKE;
						state_d       = prq_pkg::ST_RSCAN;
					end
				end else begin
					early_d = sstat.empty ? '1 : sfront_tick;
					state_d = prq_pkg::ST_TPOST;
				end
			end
			prq_pkg::ST_TPOST: begin
				if (idle_q && !rstat.empty) begin
					state_d = prq_pkg::ST_YIELD;
				end else begin
					slice_d = slice_inc;
					state_d = (slice_inc >= ts_q) ? prq_pkg::ST_YIELD : prq_pkg::ST_DONE;
				end
			end
			prq_pkg::ST_DONE: state_d = prq_pkg::ST_IDLE;
			default: state_d = prq_pkg::ST_IDLE;
		endcase
	end

	`ASSERT_IMPLY(a_done_to_idle, clk, arst_n, done |=> !busy)
	`ASSERT_IMPLY(a_start_busy, clk, arst_n, (start && !busy) |=> busy)
	`ASSERT_NEVER(a_rcount_ovf, clk, arst_n, rcount > CW'(MAX_THREADS))
	`ASSERT_NEVER(a_scount_ovf, clk, arst_n, scount > CW'(MAX_THREADS))
	`ASSERT_NEVER(a_bad_status, clk, arst_n, done && status == 2'd3)
endmodule
`default_nettype wire
